// ===== rtl/ngh_pkg.sv =====
// ----------------------------------------------------------------------------
// N-gram hash head index package
// Shared types and codes for the front end, the execution unit and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ngh_pkg;

    // Input command codes as they appear on the command port.
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_COMMIT = 2'd1;
    localparam logic [1:0] CMD_WRITE  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CUR_MULT   = 2'd0;
    localparam logic [1:0] CFG_PREV_MULT  = 2'd1;
    localparam logic [1:0] CFG_PREV2_MULT = 2'd2;
    localparam logic [1:0] CFG_BOUNDARY   = 2'd3;

    // Result kinds.
    localparam logic KIND_INDEX = 1'b0;
    localparam logic KIND_ACK   = 1'b1;

    // Number of remainder bits retired per cycle.
    localparam int unsigned DIV_BITS_PER_CYCLE = 4;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_COMMIT,
        OP_WRITE
    } t_op;

    // Classified word passed from the front end to the execution unit.
    typedef struct packed {
        t_op         op;
        logic [31:0] token;
        logic [3:0]  sel;
        logic [39:0] base;
        logic [31:0] size;
        logic        bad;
    } t_cmd;

    // Result word.
    typedef struct packed {
        logic        kind;
        logic [3:0]  head_number;
        logic [40:0] row_index;
        logic        rejected;
        logic        last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_READ,
        ST_DIV,
        ST_FIX,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/ngh_fifo.sv =====
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ngh_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [AW:0]      r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    // Pointer and occupancy update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_en) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd_en) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ngh_front.sv =====
// ----------------------------------------------------------------------------
// N-gram hash front end
// Accepts input words, classifies them, checks head writes and queues all but unused commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ngh_front #(
    parameter int unsigned HEAD_COUNT = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [1:0]   i_command,
    input  wire logic [31:0]  i_token,
    input  wire logic [3:0]   i_head_select,
    input  wire logic [40:0]  i_head_base,
    input  wire logic [32:0]  i_head_size,
    input  wire logic         i_cmd_pop,
    output ngh_pkg::t_cmd     o_cmd,
    output logic              o_cmd_empty
);
    import ngh_pkg::*;

    t_cmd                    cmd;
    logic                    keep;
    logic [$bits(t_cmd)-1:0] q_rdata;

    // Decode the command and flag head writes that must be refused.
    always_comb begin
        cmd.token = i_token;
        cmd.sel   = i_head_select;
        cmd.base  = i_head_base[39:0];
        cmd.size  = i_head_size[31:0];
        cmd.bad   = ({28'd0, i_head_select} >= 32'(HEAD_COUNT)) || i_head_base[40]
                    || i_head_size[32] || (i_head_size == '0);
        cmd.op    = OP_LOOKUP;
        keep      = 1'b1;
        case (i_command)
            CMD_LOOKUP: cmd.op = OP_LOOKUP;
            CMD_COMMIT: cmd.op = OP_COMMIT;
            CMD_WRITE:  cmd.op = OP_WRITE;
            default:    keep   = 1'b0;
        endcase
    end

    // Unused commands are accepted and dropped here.
    ngh_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push && keep),
        .i_wdata (cmd),
        .o_full  (full),
        .i_rd    (i_cmd_pop),
        .o_rdata (q_rdata),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = t_cmd'(q_rdata);

endmodule

`default_nettype wire

// ===== rtl/ngh_back.sv =====
// ----------------------------------------------------------------------------
// N-gram hash execution unit
// Holds history, head table and multipliers; hashes and reduces per head.
// ----------------------------------------------------------------------------
`default_nettype none

module ngh_back #(
    parameter int unsigned HEAD_COUNT   = 16,
    parameter int unsigned BIGRAM_HEADS = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [63:0]     i_cfg_data,
    input  ngh_pkg::t_cmd        i_cmd,
    input  wire logic            i_cmd_empty,
    output logic                 o_cmd_pop,
    output ngh_pkg::t_result     o_res,
    output logic                 o_res_push,
    input  wire logic            i_res_full
);
    import ngh_pkg::*;

    localparam int unsigned HW = (HEAD_COUNT > 1) ? $clog2(HEAD_COUNT) : 1;
    localparam int unsigned DIV_STEPS = 64 / DIV_BITS_PER_CYCLE;

    t_state       r_state, n_state;

    // Configuration and history.
    logic [63:0]  r_m0, r_m1, r_m2;
    logic [31:0]  r_boundary;
    logic [31:0]  r_prior, r_prior2;

    // Head table with per-entry valid bits.
    logic [39:0]  r_tbl_off  [HEAD_COUNT];
    logic [31:0]  r_tbl_size [HEAD_COUNT];
    logic [HEAD_COUNT-1:0] r_tbl_valid;
    logic [39:0]  r_rd_off;
    logic [31:0]  r_rd_size;
    logic         r_rd_valid;
    logic         tbl_we;
    logic [6:0]   sel_ext;
    logic [HW-1:0] waddr;

    // Hash datapath.
    logic [31:0]  r_tok;
    logic [2:0]   r_mstep;
    logic [63:0]  r_prod;
    logic [63:0]  r_term;
    logic [63:0]  r_big, r_tri;
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_m;
    logic [1:0]   cons_j;
    logic [31:0]  cons_a;
    logic [63:0]  cons_m;
    logic [63:0]  term_done;

    // Reduction datapath.
    logic [HW-1:0] r_head;
    logic [HW-1:0] head_nxt;
    logic [6:0]   head_ext;
    logic         use_big;
    logic [63:0]  hash;
    logic [3:0]   r_dcnt;
    logic [63:0]  r_mag;
    logic [31:0]  r_rem;
    logic         r_neg;
    logic [31:0]  r_size;
    logic [39:0]  r_off;
    logic [31:0]  r_adj;
    logic [31:0]  div_rem;
    logic [63:0]  div_mag;
    logic [32:0]  div_t;
    logic         last_head;

    assign sel_ext   = {3'd0, i_cmd.sel};
    assign waddr     = sel_ext[HW-1:0];
    assign head_ext  = 7'(r_head);
    assign use_big   = head_ext < 7'(BIGRAM_HEADS);
    assign hash      = use_big ? r_big : r_tri;
    assign last_head = (head_ext == 7'(HEAD_COUNT - 1));

    // Head index for the next cycle, so that the table read keeps pace with it.
    assign head_nxt  = (r_state == ST_EMIT && !i_res_full && !last_head) ?
                       r_head + 1'b1 : r_head;

    // Multiplier operand selection: even steps take the low multiplier word.
    always_comb begin
        case (r_mstep[2:1])
            2'd0:    begin mul_a = r_tok;    mul_m = r_m0; end
            2'd1:    begin mul_a = r_prior;  mul_m = r_m1; end
            default: begin mul_a = r_prior2; mul_m = r_m2; end
        endcase
        mul_b = r_mstep[0] ? mul_m[63:32] : mul_m[31:0];
    end

    // Finish a product: add the cross term and the sign correction.
    always_comb begin
        cons_j = 2'((r_mstep - 3'd1) >> 1);
        case (cons_j)
            2'd0:    begin cons_a = r_tok;    cons_m = r_m0; end
            2'd1:    begin cons_a = r_prior;  cons_m = r_m1; end
            default: begin cons_a = r_prior2; cons_m = r_m2; end
        endcase
        term_done = {r_term[63:32] + r_prod[31:0] - (cons_a[31] ? cons_m[31:0] : 32'd0),
                     r_term[31:0]};
    end

    // Four restoring remainder steps per cycle.
    always_comb begin
        div_rem = r_rem;
        div_mag = r_mag;
        div_t   = '0;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
            div_t   = {div_rem, div_mag[63]};
            div_mag = {div_mag[62:0], 1'b0};
            if (div_t >= {1'b0, r_size}) begin
                div_t = div_t - {1'b0, r_size};
            end
            div_rem = div_t[31:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty && i_cmd.op == OP_LOOKUP) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  if (r_mstep == 3'd6) n_state = ST_READ;
            ST_READ: n_state = ST_DIV;
            ST_DIV:  if (r_dcnt == 4'(DIV_STEPS - 1)) n_state = ST_FIX;
            ST_FIX:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (!i_res_full) begin
                    n_state = last_head ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        tbl_we     = 1'b0;
        o_res.kind        = KIND_INDEX;
        o_res.head_number = head_ext[3:0];
        o_res.row_index   = {1'b0, r_off} + {9'd0, r_adj};
        o_res.rejected    = 1'b0;
        o_res.last        = last_head;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    case (i_cmd.op)
                        OP_WRITE: begin
                            o_res.kind        = KIND_ACK;
                            o_res.head_number = i_cmd.sel;
                            o_res.row_index   = '0;
                            o_res.rejected    = i_cmd.bad;
                            o_res.last        = 1'b1;
                            if (!i_res_full) begin
                                o_cmd_pop  = 1'b1;
                                o_res_push = 1'b1;
                                tbl_we     = !i_cmd.bad;
                            end
                        end
                        default: o_cmd_pop = 1'b1;
                    endcase
                end
            end
            ST_EMIT: o_res_push = !i_res_full;
            default: ;
        endcase
    end

    // Control, configuration and history registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_m0        <= '0;
            r_m1        <= '0;
            r_m2        <= '0;
            r_boundary  <= '1;
            r_prior     <= '1;
            r_prior2    <= '1;
            r_tbl_valid <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CUR_MULT:   r_m0 <= i_cfg_data;
                    CFG_PREV_MULT:  r_m1 <= i_cfg_data;
                    CFG_PREV2_MULT: r_m2 <= i_cfg_data;
                    CFG_BOUNDARY:   r_boundary <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (r_state == ST_IDLE && o_cmd_pop && i_cmd.op == OP_COMMIT) begin
                if (i_cmd.token == r_boundary) begin
                    r_prior  <= r_boundary;
                    r_prior2 <= r_boundary;
                end else begin
                    r_prior2 <= r_prior;
                    r_prior  <= i_cmd.token;
                end
            end
            if (tbl_we) begin
                r_tbl_valid[waddr] <= 1'b1;
            end
        end
    end

    // Head table storage with registered read at the head of the next cycle.
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_off[waddr]  <= i_cmd.base;
            r_tbl_size[waddr] <= i_cmd.size;
        end
        r_rd_off   <= r_tbl_off[head_nxt];
        r_rd_size  <= r_tbl_size[head_nxt];
        r_rd_valid <= r_tbl_valid[head_nxt];
    end

    // Hash and reduction datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_tok   <= i_cmd.token;
                r_mstep <= '0;
                r_head  <= '0;
            end
            ST_MUL: begin
                r_mstep <= r_mstep + 3'd1;
                r_prod  <= mul_a * mul_b;
                if (r_mstep != 3'd0) begin
                    if (r_mstep[0]) begin
                        r_term <= r_prod;
                    end else begin
                        case (cons_j)
                            2'd0:    r_big <= term_done;
                            2'd1:    r_big <= r_big ^ term_done;
                            default: r_tri <= r_big ^ term_done;
                        endcase
                    end
                end
            end
            ST_READ: begin
                r_neg  <= hash[63];
                r_mag  <= hash[63] ? (~hash + 64'd1) : hash;
                r_size <= r_rd_valid ? r_rd_size : 32'd1;
                r_off  <= r_rd_valid ? r_rd_off : 40'd0;
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            ST_DIV: begin
                r_rem  <= div_rem;
                r_mag  <= div_mag;
                r_dcnt <= r_dcnt + 4'd1;
            end
            ST_FIX: begin
                r_adj <= (r_neg && r_rem != '0) ? (r_size - r_rem) : r_rem;
            end
            ST_EMIT: begin
                if (!i_res_full && !last_head) begin
                    r_head <= r_head + 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ngram_hash_head_index.sv =====
// Lookup: the shared 32x32 multiplier makes six passes per lookup, then each
// head in turn is reduced by the 4-bit-per-cycle remainder unit into an index.
// A commit updates the history; an accepted head write updates the head
// table, and every write is answered with an acknowledge. Synchronous
// active-low reset clears queues, multipliers and head-table valid bits and
// sets history to all ones; unwritten heads read as offset 0, size 1.
`default_nettype none

module ngram_hash_head_index #(
    parameter int unsigned HEAD_COUNT   = 16,
    parameter int unsigned BIGRAM_HEADS = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [1:0]   i_command,
    input  wire logic [31:0]  i_token,
    input  wire logic [3:0]   i_head_select,
    input  wire logic [40:0]  i_head_base,
    input  wire logic [32:0]  i_head_size,
    output logic              empty,
    input  wire logic         pop,
    output logic              o_kind,
    output logic [3:0]        o_head_number,
    output logic [40:0]       o_row_index,
    output logic              o_rejected,
    output logic              o_last,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);
    import ngh_pkg::*;

    t_cmd                       cmd;
    logic                       cmd_empty;
    logic                       cmd_pop;
    t_result                    res_in;
    t_result                    res_out;
    logic                       res_push;
    logic                       res_full;
    logic [$bits(t_result)-1:0] res_rdata;

    assign o_cfg_ready = 1'b1;

    // Front end: classify and queue input words.
    ngh_front #(
        .HEAD_COUNT (HEAD_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_command     (i_command),
        .i_token       (i_token),
        .i_head_select (i_head_select),
        .i_head_base   (i_head_base),
        .i_head_size   (i_head_size),
        .i_cmd_pop     (cmd_pop),
        .o_cmd         (cmd),
        .o_cmd_empty   (cmd_empty)
    );

    // Execution unit.
    ngh_back #(
        .HEAD_COUNT   (HEAD_COUNT),
        .BIGRAM_HEADS (BIGRAM_HEADS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res_in),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    // Result queue towards the consumer.
    ngh_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (res_rdata),
        .o_empty (empty)
    );

    assign res_out       = t_result'(res_rdata);
    assign o_kind        = res_out.kind;
    assign o_head_number = res_out.head_number;
    assign o_row_index   = res_out.row_index;
    assign o_rejected    = res_out.rejected;
    assign o_last        = res_out.last;

endmodule

`default_nettype wire
